[hdl/mspe_pkg.sv]
// shared types and constants of the multi-axis step pulse emitter
// no dependencies; used by the lanes, the top level and the checker
package mspe_pkg;

  localparam int MAX_AXES   = 4;
  localparam int DELTA_W    = 16;
  localparam int CNT_W      = DELTA_W + 1;
  localparam int POS_W      = 32;
  localparam int INTERVAL_W = 32;
  localparam int BYTE_W     = 2 * MAX_AXES;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_ESTOP = 2'd2
  } func_e;

  typedef struct packed {
    logic [1:0]                   func;
    logic signed [DELTA_W-1:0]    delta_x;
    logic signed [DELTA_W-1:0]    delta_y;
    logic signed [DELTA_W-1:0]    delta_z;
    logic signed [DELTA_W-1:0]    delta_a;
    logic [INTERVAL_W-1:0]        step_interval;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0]            stream_byte;
    logic                         byte_valid;
    logic                         segment_done;
    logic                         aborted;
    logic signed [POS_W-1:0]      pos_x;
    logic signed [POS_W-1:0]      pos_y;
    logic signed [POS_W-1:0]      pos_z;
    logic signed [POS_W-1:0]      pos_a;
  } out_t;

  // control from the segment sequencer to each axis lane
  typedef struct packed {
    logic               load;
    logic               step;
    logic               commit;
    logic               clear;
    logic [DELTA_W-1:0] major;
    logic [DELTA_W-1:0] acc_init;
  } lane_ctrl_t;

endpackage

[hdl/mspe_axis.sv]
// one axis lane: magnitude, bresenham error term, step count and position
// depends on mspe_pkg
module mspe_axis (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mspe_pkg::lane_ctrl_t                ctrl_i,
  input  logic signed [mspe_pkg::DELTA_W-1:0] delta_i,
  output logic [mspe_pkg::DELTA_W-1:0]        mag_o,
  output logic                                dir_o,
  output logic                                step_o,
  output logic signed [mspe_pkg::POS_W-1:0]   pos_next_o
);

  logic [mspe_pkg::DELTA_W-1:0]      mag_q, mag_d;
  logic [mspe_pkg::DELTA_W-1:0]      acc_q, acc_d;
  logic                              dir_q, dir_d;
  logic signed [mspe_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic signed [mspe_pkg::POS_W-1:0] pos_q, pos_d;

  logic [mspe_pkg::DELTA_W-1:0]      mag_new;
  logic                              dir_new;
  logic [mspe_pkg::DELTA_W:0]        sum;
  logic                              fire;
  logic signed [mspe_pkg::CNT_W-1:0] cnt_step;
  logic signed [mspe_pkg::POS_W-1:0] pos_sum;

  // most negative delta maps to its own bit pattern, read as unsigned
  assign mag_new = delta_i[mspe_pkg::DELTA_W-1] ? (~delta_i + 1'b1) : delta_i;
  assign dir_new = !delta_i[mspe_pkg::DELTA_W-1] && (delta_i != '0);

  assign sum  = {1'b0, acc_q} + {1'b0, mag_q};
  assign fire = (mag_q != '0) && (sum >= {1'b0, ctrl_i.major});

  assign cnt_step = fire ? (cnt_q + (dir_q ? mspe_pkg::CNT_W'(1) : {mspe_pkg::CNT_W{1'b1}}))
                         : cnt_q;
  assign pos_sum  = pos_q + {{(mspe_pkg::POS_W-mspe_pkg::CNT_W){cnt_step[mspe_pkg::CNT_W-1]}},
                             cnt_step};

  always_comb begin
    mag_d = mag_q;
    dir_d = dir_q;
    acc_d = acc_q;
    cnt_d = cnt_q;
    pos_d = pos_q;
    if (ctrl_i.load) begin
      mag_d = mag_new;
      dir_d = dir_new;
      acc_d = ctrl_i.acc_init;
      cnt_d = '0;
    end else if (ctrl_i.step) begin
      // the error term grows by the magnitude on every step, wrapping back when it fires
      acc_d = fire ? mspe_pkg::DELTA_W'(sum - {1'b0, ctrl_i.major})
                   : sum[mspe_pkg::DELTA_W-1:0];
      cnt_d = ctrl_i.commit ? '0 : cnt_step;
      if (ctrl_i.commit) begin
        pos_d = pos_sum;
      end
    end else if (ctrl_i.clear) begin
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q <= '0;
      dir_q <= 1'b0;
      acc_q <= '0;
      cnt_q <= '0;
      pos_q <= '0;
    end else begin
      mag_q <= mag_d;
      dir_q <= dir_d;
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      pos_q <= pos_d;
    end
  end

  assign mag_o      = mag_new;
  assign dir_o      = dir_q;
  assign step_o     = fire;
  assign pos_next_o = pos_d;

endmodule

[hdl/multi_axis_step_pulse_emitter.sv]
// top level of the multi-axis step pulse emitter: sequencer and output queue
// depends on mspe_pkg and mspe_axis
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_ready_o | mspe_pkg::in_t
//   out     | output    | out_valid_o/out_ready_i | mspe_pkg::out_t
//
// while in_ready_o is high one item is accepted per cycle; any result is registered
// per-item path: 17-bit error add and compare per axis, then count and position adds
// results go into a two-entry queue (output register plus skid); in_ready_o drops only
// when both entries are full
// reset clears the segment, all step counts and the positions
module multi_axis_step_pulse_emitter #(
  parameter int AXES = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mspe_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mspe_pkg::out_t out_data_o
);

  localparam int NA = mspe_pkg::MAX_AXES;
  localparam int DW = mspe_pkg::DELTA_W;

  logic                             busy_q, busy_d;
  logic [DW-1:0]                    major_q, major_d;
  logic [DW-1:0]                    step_idx_q, step_idx_d;
  logic [mspe_pkg::INTERVAL_W-1:0]  interval_q, interval_d;
  logic [mspe_pkg::INTERVAL_W-1:0]  tick_q, tick_d;

  logic                             in_acc;
  logic                             is_load, is_tick, is_estop;
  logic [mspe_pkg::INTERVAL_W:0]    tick_inc;
  logic                             tick_fire;
  logic [DW:0]                      step_next;
  logic                             last_step;

  logic signed [DW-1:0]             delta [NA];
  logic [DW-1:0]                    mag [NA];
  logic [NA-1:0]                    dir_bits, step_bits;
  logic signed [mspe_pkg::POS_W-1:0] pos_next [NA];
  logic [DW-1:0]                    max01, max23, max_all;

  mspe_pkg::lane_ctrl_t             ctrl;
  logic                             has_result;
  mspe_pkg::out_t                   res;

  mspe_pkg::out_t                   out_q, out_d, skid_q, skid_d;
  logic                             out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic                             pop;

  assign in_ready_o = !skid_valid_q;
  assign in_acc     = in_valid_i && in_ready_o;

  assign is_load  = (in_data_i.func == mspe_pkg::FUNC_LOAD) && !busy_q;
  assign is_tick  = (in_data_i.func == mspe_pkg::FUNC_TICK) && busy_q;
  assign is_estop = (in_data_i.func == mspe_pkg::FUNC_ESTOP) && busy_q;

  assign tick_inc  = {1'b0, tick_q} + 1'b1;
  assign tick_fire = !(tick_inc < {1'b0, interval_q});
  assign step_next = {1'b0, step_idx_q} + 1'b1;
  assign last_step = step_next >= {1'b0, major_q};

  assign delta[0] = in_data_i.delta_x;
  assign delta[1] = in_data_i.delta_y;
  assign delta[2] = in_data_i.delta_z;
  assign delta[3] = in_data_i.delta_a;

  assign ctrl.load     = in_acc && is_load;
  assign ctrl.step     = in_acc && is_tick && tick_fire;
  assign ctrl.commit   = in_acc && is_tick && tick_fire && last_step;
  assign ctrl.clear    = in_acc && is_estop;
  assign ctrl.major    = major_q;
  assign ctrl.acc_init = max_all >> 1;

  for (genvar i = 0; i < NA; i++) begin : g_axis
    if (i < AXES) begin : g_lane
      mspe_axis u_axis (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (ctrl),
        .delta_i    (delta[i]),
        .mag_o      (mag[i]),
        .dir_o      (dir_bits[i]),
        .step_o     (step_bits[i]),
        .pos_next_o (pos_next[i])
      );
    end else begin : g_none
      assign mag[i]       = '0;
      assign dir_bits[i]  = 1'b0;
      assign step_bits[i] = 1'b0;
      assign pos_next[i]  = '0;
    end
  end

  assign max01   = (mag[0] > mag[1]) ? mag[0] : mag[1];
  assign max23   = (mag[2] > mag[3]) ? mag[2] : mag[3];
  assign max_all = (max01 > max23) ? max01 : max23;

  // sequencer state
  always_comb begin
    busy_d     = busy_q;
    major_d    = major_q;
    step_idx_d = step_idx_q;
    interval_d = interval_q;
    tick_d     = tick_q;
    if (in_acc) begin
      if (is_load) begin
        busy_d     = (max_all != '0);
        major_d    = max_all;
        step_idx_d = '0;
        tick_d     = '0;
        interval_d = in_data_i.step_interval;
      end else if (is_tick) begin
        if (tick_fire) begin
          tick_d     = '0;
          step_idx_d = step_next[DW-1:0];
          if (last_step) begin
            busy_d = 1'b0;
          end
        end else begin
          tick_d = tick_inc[mspe_pkg::INTERVAL_W-1:0];
        end
      end else if (is_estop) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      major_q    <= '0;
      step_idx_q <= '0;
      interval_q <= '0;
      tick_q     <= '0;
    end else begin
      busy_q     <= busy_d;
      major_q    <= major_d;
      step_idx_q <= step_idx_d;
      interval_q <= interval_d;
      tick_q     <= tick_d;
    end
  end

  // result of the accepted item
  always_comb begin
    res              = '0;
    has_result       = 1'b0;
    if (ctrl.step) begin
      has_result     = 1'b1;
      res.byte_valid = 1'b1;
      res.segment_done = last_step;
      for (int i = 0; i < NA; i++) begin
        res.stream_byte[2*i]   = step_bits[i];
        res.stream_byte[2*i+1] = dir_bits[i];
      end
    end else if (ctrl.load && (max_all == '0)) begin
      has_result       = 1'b1;
      res.segment_done = 1'b1;
    end else if (ctrl.clear) begin
      has_result   = 1'b1;
      res.aborted  = 1'b1;
    end
    res.pos_x = pos_next[0];
    res.pos_y = pos_next[1];
    res.pos_z = pos_next[2];
    res.pos_a = pos_next[3];
  end

  // output register with a skid entry behind it
  assign pop = out_valid_q && out_ready_i;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (out_valid_q && !pop) begin
      if (has_result) begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else begin
      out_valid_d = has_result;
      if (has_result) begin
        out_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hdl/mspe_checker.sv]
// port-level checks of the multi-axis step pulse emitter, bound to the top level
// depends on mspe_pkg
module mspe_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input mspe_pkg::out_t out_data_o
);

  localparam logic [mspe_pkg::BYTE_W-1:0] StepMask = 8'h55;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // the major axis steps on every emitted byte
  a_major_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.byte_valid |-> (out_data_o.stream_byte & StepMask) != '0)
    else $error("byte without any step bit");

  a_quiet_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |-> out_data_o.stream_byte == '0)
    else $error("stream byte set without byte_valid");

  a_abort_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.aborted |-> !out_data_o.byte_valid && !out_data_o.segment_done)
    else $error("abort mixed with step or completion");

endmodule

bind multi_axis_step_pulse_emitter mspe_checker u_mspe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
